// ===== hw/rtl/gram_schmidt_qr_core_assert.svh =====
// assertion macros shared by the checker of the qr core
`ifndef GRAM_SCHMIDT_QR_CORE_ASSERT_SVH
`define GRAM_SCHMIDT_QR_CORE_ASSERT_SVH

// same-cycle implication, clocked on clk, quiet during reset
`define GSQR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, clocked on clk, quiet during reset
`define GSQR_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/gsqr_pkg.sv =====
// shared constants, types and helpers of the gram-schmidt qr core
`default_nettype none

package gsqr_pkg;

  localparam int DIM_DEF       = 5;
  localparam int FRAC_BITS_DEF = 16;
  localparam int ELEM_W        = 32;
  localparam int IDX_W         = 3;
  localparam int SIZE_W        = 3;
  localparam logic [SIZE_W-1:0] SIZE_RESET = 3'd4;
  localparam int SQRT_STEPS    = 44;

  localparam logic MATRIX_Q = 1'b0;
  localparam logic MATRIX_R = 1'b1;

  localparam logic signed [ELEM_W-1:0] ELEM_MAX = 32'sh7fff_ffff;
  localparam logic signed [ELEM_W-1:0] ELEM_MIN = 32'sh8000_0000;

  // request from the sequencer to the divide / root unit
  typedef struct packed {
    logic               div_start;
    logic               sqrt_start;
    logic signed [63:0] num;
    logic [63:0]        den;
  } gsqr_arith_req_t;

  // answer of the divide / root unit
  typedef struct packed {
    logic                     div_done;
    logic signed [ELEM_W-1:0] quot;
    logic                     sqrt_done;
    logic [SQRT_STEPS-1:0]    root;
  } gsqr_arith_rsp_t;

  // saturate a 64-bit value to a 32-bit element
  function automatic logic signed [ELEM_W-1:0] sat32(input logic signed [63:0] x);
    logic signed [63:0] hi;
    logic signed [63:0] lo;
    hi = 64'(ELEM_MAX);
    lo = 64'(ELEM_MIN);
    if (x > hi) begin
      return ELEM_MAX;
    end else if (x < lo) begin
      return ELEM_MIN;
    end
    return x[ELEM_W-1:0];
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/gsqr_channels.sv =====
// valid/ready channel interfaces of the qr core
`default_nettype none

interface gsqr_in_if import gsqr_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [ELEM_W-1:0] element_value;
  modport source(output valid, output element_value, input ready);
  modport sink(input valid, input element_value, output ready);
endinterface

interface gsqr_out_if import gsqr_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic                     which_matrix;
  logic [IDX_W-1:0]         row_index;
  logic [IDX_W-1:0]         col_index;
  logic signed [ELEM_W-1:0] result_value;
  logic                     zero_norm_seen;
  logic                     last_result;
  modport source(output valid, output which_matrix, output row_index, output col_index,
                 output result_value, output zero_norm_seen, output last_result,
                 input ready);
  modport sink(input valid, input which_matrix, input row_index, input col_index,
               input result_value, input zero_norm_seen, input last_result,
               output ready);
endinterface

interface gsqr_cfg_if import gsqr_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [SIZE_W-1:0] size_in_use;
  modport source(output valid, output size_in_use, input ready);
  modport sink(input valid, input size_in_use, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/gram_schmidt_qr_core.sv =====
// qr decomposition by classical gram-schmidt: load, orthogonalize, normalize, emit q and r
// loading: one item per cycle while no size write is offered, n*n items; the matrix store is written as items arrive
// compute: each projection needs one divide, each column of nonzero norm one root and n divides;
//   dot products go element by element through one multiplier
// output: all of q first, then r, each r element computed as a dot product before it is emitted
// reset: size in use returns to 4 and any partly loaded matrix is dropped; no store is cleared
`default_nettype none

module gram_schmidt_qr_core import gsqr_pkg::*; #(
  parameter int DIM       = DIM_DEF,
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  gsqr_cfg_if.sink  cfg_ch,
  gsqr_in_if.sink   in_ch,
  gsqr_out_if.source out_ch
);

  localparam int IW    = $clog2(DIM);
  localparam int DEPTH = DIM * DIM;
  localparam int AW    = $clog2(DEPTH);

  typedef enum logic [4:0] {
    S_LOAD, S_ACC_RD, S_ACC_WR, S_PJ_CHK, S_PD_RD, S_PD_MUL, S_PD_ACC, S_PD_DIV,
    S_PD_WAIT, S_PS_RD, S_PS_MUL, S_PS_ACC, S_VW, S_VACC, S_NM_CHK, S_NZ, S_NM_SQ,
    S_NM_RD, S_NM_DIV, S_NM_WAIT, S_NM_NEXT, S_QO_RD, S_QO_PUT, S_RD_RD, S_RD_MUL,
    S_RD_ACC, S_RO_PUT
  } state_t;

  state_t                   state_r;
  logic [SIZE_W-1:0]        size_r;
  logic [IW-1:0]            load_row_r;
  logic [IW-1:0]            load_col_r;
  logic [IW-1:0]            i_r;
  logic [IW-1:0]            j_r;
  logic [IW-1:0]            k_r;
  logic [IW-1:0]            r_r;
  logic signed [63:0]       acc_r [DIM];
  logic signed [63:0]       nsq_r [DIM];
  logic signed [63:0]       dot_r;
  logic signed [63:0]       prod_r;
  logic signed [ELEM_W-1:0] c_r;
  logic [63:0]              m_r;
  logic                     zero_seen_r;

  logic                     out_valid_r;
  logic                     out_which_r;
  logic [IDX_W-1:0]         out_row_r;
  logic [IDX_W-1:0]         out_col_r;
  logic signed [ELEM_W-1:0] out_value_r;
  logic                     out_zero_r;
  logic                     out_last_r;

  logic [IW-1:0]            last_idx;
  logic                     in_accept;
  logic                     cfg_accept;
  logic                     slot_free;
  logic                     out_load;

  logic                     in_we;
  logic [AW-1:0]            in_waddr;
  logic                     in_re;
  logic [AW-1:0]            in_raddr;
  logic signed [ELEM_W-1:0] in_rdata;
  logic                     bs_we;
  logic [AW-1:0]            bs_waddr;
  logic signed [ELEM_W-1:0] bs_wdata;
  logic                     bs_re;
  logic [AW-1:0]            bs_raddr;
  logic signed [ELEM_W-1:0] bs_rdata;

  logic signed [ELEM_W-1:0] mul_a;
  logic signed [ELEM_W-1:0] mul_b;
  logic signed [63:0]       prod_full;
  logic signed [64:0]       prod_bias;
  logic signed [64:0]       prod_sh;
  logic signed [63:0]       prod_rnd;
  logic signed [63:0]       dot_sum;
  logic signed [ELEM_W-1:0] acc_sat;

  gsqr_arith_req_t arith_req;
  gsqr_arith_rsp_t arith_rsp;

  function automatic logic [AW-1:0] addr_of(input logic [IW-1:0] a, input logic [IW-1:0] b);
    return AW'(a) * AW'(DIM) + AW'(b);
  endfunction

  // matrix size in use, clamped to 2..DIM, as its last index
  always_comb begin
    if (size_r < SIZE_W'(2)) begin
      last_idx = IW'(1);
    end else if (int'(size_r) > DIM) begin
      last_idx = IW'(DIM - 1);
    end else begin
      last_idx = IW'(size_r - SIZE_W'(1));
    end
  end

  assign in_accept  = in_ch.valid && in_ch.ready;
  assign cfg_accept = cfg_ch.valid && cfg_ch.ready;
  assign slot_free  = !out_valid_r || out_ch.ready;
  assign out_load   = ((state_r == S_QO_PUT) || (state_r == S_RO_PUT)) && slot_free;

  // shared multiplier and product rounding
  always_comb begin
    acc_sat = sat32(acc_r[r_r]);
    case (state_r)
      S_PD_MUL, S_RD_MUL: begin
        mul_a = in_rdata;
        mul_b = bs_rdata;
      end
      S_PS_MUL: begin
        mul_a = c_r;
        mul_b = bs_rdata;
      end
      S_VW: begin
        mul_a = acc_sat;
        mul_b = acc_sat;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    prod_full = mul_a * mul_b;
    prod_bias = {prod_r[63], prod_r} + (65'sd1 <<< (FRAC_BITS - 1));
    prod_sh   = prod_bias >>> FRAC_BITS;
    prod_rnd  = prod_sh[63:0];
    dot_sum   = dot_r + prod_rnd;
  end

  // memory ports driven by the sequencer
  always_comb begin
    in_we    = in_accept;
    in_waddr = addr_of(load_row_r, load_col_r);
    in_re    = 1'b0;
    in_raddr = addr_of(r_r, i_r);
    bs_we    = 1'b0;
    bs_waddr = addr_of(i_r, r_r);
    bs_wdata = '0;
    bs_re    = 1'b0;
    bs_raddr = addr_of(j_r, r_r);
    case (state_r)
      S_ACC_RD: in_re = 1'b1;
      S_PD_RD: begin
        in_re = 1'b1;
        bs_re = 1'b1;
      end
      S_PS_RD: bs_re = 1'b1;
      S_VW: begin
        bs_we    = 1'b1;
        bs_wdata = acc_sat;
      end
      S_NZ: bs_we = 1'b1;
      S_NM_RD: begin
        bs_re    = 1'b1;
        bs_raddr = addr_of(i_r, r_r);
      end
      S_NM_WAIT: begin
        bs_we    = arith_rsp.div_done;
        bs_wdata = arith_rsp.quot;
      end
      S_QO_RD: begin
        bs_re    = 1'b1;
        bs_raddr = addr_of(k_r, r_r);
      end
      S_RD_RD: begin
        in_re    = 1'b1;
        in_raddr = addr_of(r_r, k_r);
        bs_re    = 1'b1;
        bs_raddr = addr_of(i_r, r_r);
      end
      default: ;
    endcase
  end

  // requests to the divide / root unit
  always_comb begin
    arith_req.div_start  = (state_r == S_PD_DIV) || (state_r == S_NM_DIV);
    arith_req.sqrt_start = (state_r == S_NM_CHK) && (nsq_r[i_r] > 64'sd0);
    if (state_r == S_PD_DIV) begin
      arith_req.num = dot_r;
      arith_req.den = 64'(nsq_r[j_r]);
    end else if (state_r == S_NM_DIV) begin
      arith_req.num = 64'(bs_rdata);
      arith_req.den = m_r;
    end else begin
      arith_req.num = nsq_r[i_r];
      arith_req.den = m_r;
    end
  end

  gsqr_ram #(.WIDTH(ELEM_W), .DEPTH(DEPTH)) u_in_ram (
    .clk   (clk),
    .we    (in_we),
    .waddr (in_waddr),
    .wdata (in_ch.element_value),
    .re    (in_re),
    .raddr (in_raddr),
    .rdata (in_rdata)
  );

  gsqr_ram #(.WIDTH(ELEM_W), .DEPTH(DEPTH)) u_bs_ram (
    .clk   (clk),
    .we    (bs_we),
    .waddr (bs_waddr),
    .wdata (bs_wdata),
    .re    (bs_re),
    .raddr (bs_raddr),
    .rdata (bs_rdata)
  );

  gsqr_arith #(.FRAC_BITS(FRAC_BITS)) u_arith (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (arith_req),
    .rsp   (arith_rsp)
  );

  // sequencer, working registers and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_LOAD;
      size_r      <= SIZE_RESET;
      load_row_r  <= '0;
      load_col_r  <= '0;
      i_r         <= '0;
      j_r         <= '0;
      k_r         <= '0;
      r_r         <= '0;
      zero_seen_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      case (state_r)
        // matrix load, row-major
        S_LOAD: begin
          if (in_accept) begin
            if (load_col_r == last_idx) begin
              load_col_r <= '0;
              if (load_row_r == last_idx) begin
                load_row_r  <= '0;
                i_r         <= '0;
                r_r         <= '0;
                zero_seen_r <= 1'b0;
                state_r     <= S_ACC_RD;
              end else begin
                load_row_r <= load_row_r + IW'(1);
              end
            end else begin
              load_col_r <= load_col_r + IW'(1);
            end
          end
        end
        // copy column i into the accumulators
        S_ACC_RD: state_r <= S_ACC_WR;
        S_ACC_WR: begin
          acc_r[r_r] <= 64'(in_rdata);
          if (r_r == last_idx) begin
            r_r     <= '0;
            j_r     <= '0;
            state_r <= S_PJ_CHK;
          end else begin
            r_r     <= r_r + IW'(1);
            state_r <= S_ACC_RD;
          end
        end
        // next earlier basis vector, skipping zero norms
        S_PJ_CHK: begin
          dot_r <= '0;
          r_r   <= '0;
          if (j_r == i_r) begin
            state_r <= S_VW;
          end else if (nsq_r[j_r] == 64'sd0) begin
            j_r <= j_r + IW'(1);
          end else begin
            state_r <= S_PD_RD;
          end
        end
        // dot of the original column with basis vector j
        S_PD_RD: state_r <= S_PD_MUL;
        S_PD_MUL: begin
          prod_r  <= prod_full;
          state_r <= S_PD_ACC;
        end
        S_PD_ACC: begin
          dot_r <= dot_sum;
          if (r_r == last_idx) begin
            state_r <= S_PD_DIV;
          end else begin
            r_r     <= r_r + IW'(1);
            state_r <= S_PD_RD;
          end
        end
        S_PD_DIV: state_r <= S_PD_WAIT;
        S_PD_WAIT: begin
          if (arith_rsp.div_done) begin
            c_r     <= arith_rsp.quot;
            r_r     <= '0;
            state_r <= S_PS_RD;
          end
        end
        // subtract the projection
        S_PS_RD: state_r <= S_PS_MUL;
        S_PS_MUL: begin
          prod_r  <= prod_full;
          state_r <= S_PS_ACC;
        end
        S_PS_ACC: begin
          acc_r[r_r] <= acc_r[r_r] - prod_rnd;
          if (r_r == last_idx) begin
            r_r     <= '0;
            j_r     <= j_r + IW'(1);
            state_r <= S_PJ_CHK;
          end else begin
            r_r     <= r_r + IW'(1);
            state_r <= S_PS_RD;
          end
        end
        // store basis vector i and its squared norm
        S_VW: begin
          prod_r  <= prod_full;
          state_r <= S_VACC;
        end
        S_VACC: begin
          dot_r <= dot_sum;
          if (r_r == last_idx) begin
            nsq_r[i_r] <= dot_sum;
            r_r        <= '0;
            if (i_r == last_idx) begin
              i_r     <= '0;
              state_r <= S_NM_CHK;
            end else begin
              i_r     <= i_r + IW'(1);
              state_r <= S_ACC_RD;
            end
          end else begin
            r_r     <= r_r + IW'(1);
            state_r <= S_VW;
          end
        end
        // normalize column i, or zero it
        S_NM_CHK: begin
          r_r <= '0;
          if (nsq_r[i_r] <= 64'sd0) begin
            zero_seen_r <= 1'b1;
            state_r     <= S_NZ;
          end else begin
            state_r <= S_NM_SQ;
          end
        end
        S_NZ: begin
          if (r_r == last_idx) begin
            state_r <= S_NM_NEXT;
          end else begin
            r_r <= r_r + IW'(1);
          end
        end
        S_NM_SQ: begin
          if (arith_rsp.sqrt_done) begin
            m_r     <= 64'(arith_rsp.root);
            state_r <= S_NM_RD;
          end
        end
        S_NM_RD:  state_r <= S_NM_DIV;
        S_NM_DIV: state_r <= S_NM_WAIT;
        S_NM_WAIT: begin
          if (arith_rsp.div_done) begin
            if (r_r == last_idx) begin
              state_r <= S_NM_NEXT;
            end else begin
              r_r     <= r_r + IW'(1);
              state_r <= S_NM_RD;
            end
          end
        end
        S_NM_NEXT: begin
          r_r <= '0;
          if (i_r == last_idx) begin
            k_r     <= '0;
            state_r <= S_QO_RD;
          end else begin
            i_r     <= i_r + IW'(1);
            state_r <= S_NM_CHK;
          end
        end
        // emit q row-major
        S_QO_RD: state_r <= S_QO_PUT;
        S_QO_PUT: begin
          if (slot_free) begin
            out_which_r <= MATRIX_Q;
            out_row_r   <= IDX_W'(r_r);
            out_col_r   <= IDX_W'(k_r);
            out_value_r <= bs_rdata;
            out_zero_r  <= zero_seen_r;
            out_last_r  <= 1'b0;
            state_r     <= S_QO_RD;
            if (k_r == last_idx) begin
              k_r <= '0;
              if (r_r == last_idx) begin
                r_r     <= '0;
                i_r     <= '0;
                dot_r   <= '0;
                state_r <= S_RD_RD;
              end else begin
                r_r <= r_r + IW'(1);
              end
            end else begin
              k_r <= k_r + IW'(1);
            end
          end
        end
        // r element (i, k): dot of q column i with original column k
        S_RD_RD: state_r <= S_RD_MUL;
        S_RD_MUL: begin
          prod_r  <= prod_full;
          state_r <= S_RD_ACC;
        end
        S_RD_ACC: begin
          dot_r <= dot_sum;
          if (r_r == last_idx) begin
            state_r <= S_RO_PUT;
          end else begin
            r_r     <= r_r + IW'(1);
            state_r <= S_RD_RD;
          end
        end
        S_RO_PUT: begin
          if (slot_free) begin
            out_which_r <= MATRIX_R;
            out_row_r   <= IDX_W'(i_r);
            out_col_r   <= IDX_W'(k_r);
            out_value_r <= sat32(dot_r);
            out_zero_r  <= zero_seen_r;
            out_last_r  <= (i_r == last_idx) && (k_r == last_idx);
            dot_r       <= '0;
            r_r         <= '0;
            state_r     <= S_RD_RD;
            if (k_r == last_idx) begin
              k_r <= '0;
              if (i_r == last_idx) begin
                i_r     <= '0;
                state_r <= S_LOAD;
              end else begin
                i_r <= i_r + IW'(1);
              end
            end else begin
              k_r <= k_r + IW'(1);
            end
          end
        end
        default: state_r <= S_LOAD;
      endcase

      // output register valid: load a new item or drop the taken one
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end

      // size write drops any partial load
      if (cfg_accept) begin
        size_r     <= cfg_ch.size_in_use;
        load_row_r <= '0;
        load_col_r <= '0;
      end
    end
  end

  // size writes take priority over items and only land while loading
  assign in_ch.ready           = (state_r == S_LOAD) && !cfg_ch.valid;
  assign cfg_ch.ready          = (state_r == S_LOAD);
  assign out_ch.valid          = out_valid_r;
  assign out_ch.which_matrix   = out_which_r;
  assign out_ch.row_index      = out_row_r;
  assign out_ch.col_index      = out_col_r;
  assign out_ch.result_value   = out_value_r;
  assign out_ch.zero_norm_seen = out_zero_r;
  assign out_ch.last_result    = out_last_r;

endmodule

`default_nettype wire

// ===== hw/rtl/gsqr_ram.sv =====
// generic single-write, single-read ram with registered read data
`default_nettype none

module gsqr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 25
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// ===== hw/rtl/gsqr_arith.sv =====
// bit-serial fractional divider and digit-by-digit square root
`default_nettype none

module gsqr_arith import gsqr_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  gsqr_arith_req_t req,
  output gsqr_arith_rsp_t rsp
);

  localparam int DW   = 64 + FRAC_BITS;
  localparam int CW   = $clog2(DW + 1);
  localparam int RADW = 2 * SQRT_STEPS;
  localparam int SRW  = SQRT_STEPS + 3;
  localparam int SCW  = $clog2(SQRT_STEPS + 1);

  typedef enum logic [1:0] {P_IDLE, P_RUN, P_FIN} phase_t;

  phase_t                   div_ph_r;
  logic [CW-1:0]            div_cnt_r;
  logic [DW-1:0]            div_sh_r;
  logic [63:0]              div_rem_r;
  logic [63:0]              div_den_r;
  logic [32:0]              div_q_r;
  logic                     div_ovf_r;
  logic                     div_neg_r;
  logic                     div_done_r;
  logic signed [ELEM_W-1:0] quot_r;

  phase_t                   sq_ph_r;
  logic [SCW-1:0]           sq_cnt_r;
  logic [RADW-1:0]          sq_rad_r;
  logic [SRW-1:0]           sq_rem_r;
  logic [SQRT_STEPS-1:0]    sq_root_r;
  logic                     sq_done_r;

  logic [63:0] num_mag;
  logic [64:0] div_rem_sh;
  logic [64:0] div_den_x;
  logic        div_ge;
  logic [64:0] div_rem_sub;
  logic        div_rnd_up;
  logic [33:0] div_qr;
  logic        div_big;

  logic [SRW-1:0] sq_rem_sh;
  logic [SRW-1:0] sq_trial;
  logic           sq_ge;

  // one restoring step of the divider, plus the rounding of its result
  always_comb begin
    num_mag     = req.num[63] ? 64'(-req.num) : 64'(req.num);
    div_rem_sh  = {div_rem_r, div_sh_r[DW-1]};
    div_den_x   = {1'b0, div_den_r};
    div_ge      = div_rem_sh >= div_den_x;
    div_rem_sub = div_ge ? (div_rem_sh - div_den_x) : div_rem_sh;
    div_rnd_up  = {div_rem_r, 1'b0} >= div_den_x;
    div_qr      = {1'b0, div_q_r} + 34'(div_rnd_up);
    div_big     = div_ovf_r | div_qr[33] | div_qr[32] | div_qr[31];
  end

  // one digit of the square root
  always_comb begin
    sq_rem_sh = {sq_rem_r[SRW-3:0], sq_rad_r[RADW-1 -: 2]};
    sq_trial  = SRW'({sq_root_r, 2'b01});
    sq_ge     = sq_rem_sh >= sq_trial;
  end

  // both units and their done pulses
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_ph_r   <= P_IDLE;
      div_done_r <= 1'b0;
      sq_ph_r    <= P_IDLE;
      sq_done_r  <= 1'b0;
    end else begin
      div_done_r <= 1'b0;
      sq_done_r  <= 1'b0;

      case (div_ph_r)
        P_IDLE: begin
          if (req.div_start) begin
            div_sh_r  <= {num_mag, {FRAC_BITS{1'b0}}};
            div_neg_r <= req.num[63];
            div_den_r <= req.den;
            div_rem_r <= '0;
            div_q_r   <= '0;
            div_ovf_r <= 1'b0;
            div_cnt_r <= CW'(DW);
            div_ph_r  <= P_RUN;
          end
        end
        P_RUN: begin
          div_rem_r <= div_rem_sub[63:0];
          div_sh_r  <= {div_sh_r[DW-2:0], 1'b0};
          div_q_r   <= {div_q_r[31:0], div_ge};
          div_ovf_r <= div_ovf_r | div_q_r[32];
          div_cnt_r <= div_cnt_r - CW'(1);
          if (div_cnt_r == CW'(1)) begin
            div_ph_r <= P_FIN;
          end
        end
        P_FIN: begin
          if (div_neg_r) begin
            quot_r <= div_big ? ELEM_MIN : -$signed(div_qr[31:0]);
          end else begin
            quot_r <= div_big ? ELEM_MAX : $signed(div_qr[31:0]);
          end
          div_done_r <= 1'b1;
          div_ph_r   <= P_IDLE;
        end
        default: div_ph_r <= P_IDLE;
      endcase

      case (sq_ph_r)
        P_IDLE: begin
          if (req.sqrt_start) begin
            sq_rad_r  <= RADW'(unsigned'(req.num)) << FRAC_BITS;
            sq_rem_r  <= '0;
            sq_root_r <= '0;
            sq_cnt_r  <= SCW'(SQRT_STEPS);
            sq_ph_r   <= P_RUN;
          end
        end
        P_RUN: begin
          sq_rem_r  <= sq_ge ? (sq_rem_sh - sq_trial) : sq_rem_sh;
          sq_root_r <= {sq_root_r[SQRT_STEPS-2:0], sq_ge};
          sq_rad_r  <= sq_rad_r << 2;
          sq_cnt_r  <= sq_cnt_r - SCW'(1);
          if (sq_cnt_r == SCW'(1)) begin
            sq_ph_r <= P_FIN;
          end
        end
        P_FIN: begin
          if (sq_rem_r > SRW'(sq_root_r)) begin
            sq_root_r <= sq_root_r + SQRT_STEPS'(1);
          end
          sq_done_r <= 1'b1;
          sq_ph_r   <= P_IDLE;
        end
        default: sq_ph_r <= P_IDLE;
      endcase
    end
  end

  assign rsp.div_done  = div_done_r;
  assign rsp.quot      = quot_r;
  assign rsp.sqrt_done = sq_done_r;
  assign rsp.root      = sq_root_r;

endmodule

`default_nettype wire

// ===== hw/rtl/gsqr_checker.sv =====
// port-level checker of the qr core and its bind
`default_nettype none
`include "gram_schmidt_qr_core_assert.svh"

module gsqr_checker import gsqr_pkg::*; (
  input logic                     clk,
  input logic                     rst_n,
  input logic                     in_ready,
  input logic                     out_valid,
  input logic                     out_ready,
  input logic                     out_which,
  input logic [IDX_W-1:0]         out_row,
  input logic [IDX_W-1:0]         out_col,
  input logic signed [ELEM_W-1:0] out_value,
  input logic                     out_zero,
  input logic                     out_last
);

  // a stalled item stays put
  `GSQR_ASSERT_NXT(a_out_hold, out_valid && !out_ready,
    out_valid && $stable({out_which, out_row, out_col, out_value, out_zero, out_last}),
    "stalled result item changed")

  // the final item is the last diagonal element of r
  `GSQR_ASSERT_NOW(a_last_is_r, out_valid && out_last,
    out_which == MATRIX_R && out_row == out_col, "last flag on a wrong item")

  // no new matrix is taken while q is still being emitted
  `GSQR_ASSERT_NOW(a_no_load_in_q, out_valid && out_which == MATRIX_Q, !in_ready,
    "input ready while q items pending")

  // the zero-norm flag is constant within one matrix
  `GSQR_ASSERT_NXT(a_zero_flag_stable, out_valid && !out_last, $stable(out_zero),
    "zero-norm flag changed within a matrix")

endmodule

bind gram_schmidt_qr_core gsqr_checker u_gsqr_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_which (out_ch.which_matrix),
  .out_row   (out_ch.row_index),
  .out_col   (out_ch.col_index),
  .out_value (out_ch.result_value),
  .out_zero  (out_ch.zero_norm_seen),
  .out_last  (out_ch.last_result)
);

`default_nettype wire

// ===== bench/testbench.sv =====
// self-checking testbench of the gram-schmidt qr core with its own fixed-point qr predictor
`default_nettype none

module testbench import gsqr_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int N_MAX     = 5;
  localparam int FB        = 16;
  localparam int WDOG_MAX  = 40000;
  localparam int DRAIN_GAP = 300;
  localparam int LONG_HOLD = 3000;

  typedef struct {
    logic                     which_matrix;
    logic [IDX_W-1:0]         row_index;
    logic [IDX_W-1:0]         col_index;
    logic signed [ELEM_W-1:0] result_value;
    logic                     zero_norm_seen;
    logic                     last_result;
  } qr_elem_t;

  logic clk;
  logic rst_n;

  gsqr_cfg_if cfg_ch ();
  gsqr_in_if  in_ch ();
  gsqr_out_if out_ch ();

  gram_schmidt_qr_core dut (
    .clk   (clk),
    .rst_n (rst_n),
    .cfg_ch(cfg_ch.sink),
    .in_ch (in_ch.sink),
    .out_ch(out_ch.source)
  );

  // clock
  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // predictor state
  int                       a_mem [N_MAX*N_MAX];
  logic signed [ELEM_W-1:0] basis [N_MAX][N_MAX];
  longint                   nsq [N_MAX];
  int                       load_cnt;
  logic [SIZE_W-1:0]        size_reg;
  qr_elem_t                 expected_elems[$];

  int  mismatches;
  int  items_sent;
  bit  fast_mode;
  bit  long_hold_req;
  int  idle_cycles;

  // rounding of a product with FB fraction bits, halves up
  function automatic longint rnd_q(longint x);
    return (x >>> FB) + longint'(x[FB-1]);
  endfunction

  function automatic logic signed [ELEM_W-1:0] clamp32(longint x);
    if (x > 64'sd2147483647) return ELEM_MAX;
    if (x < -64'sd2147483648) return ELEM_MIN;
    return x[ELEM_W-1:0];
  endfunction

  function automatic longint dot_fx(logic signed [ELEM_W-1:0] x[N_MAX],
                                    logic signed [ELEM_W-1:0] y[N_MAX], int n);
    longint s;
    s = 0;
    for (int r = 0; r < n; r++) s += rnd_q(longint'(x[r]) * longint'(y[r]));
    return s;
  endfunction

  // num * 2^FB / den, rounded half away from zero, saturated
  function automatic logic signed [ELEM_W-1:0] div_fx(longint num, longint unsigned den);
    bit              neg;
    longint unsigned u, q, r;
    neg = num < 0;
    u = num;
    if (neg) u = -u;
    q = u / den;
    r = u % den;
    if (q >= 64'd2147483648) return neg ? ELEM_MIN : ELEM_MAX;
    for (int i = 0; i < FB; i++) begin
      q = q << 1;
      r = r << 1;
      if (r >= den) begin
        r = r - den;
        q = q | 64'd1;
      end
    end
    if ((r << 1) >= den) q++;
    return clamp32(neg ? -longint'(q) : longint'(q));
  endfunction

  function automatic longint unsigned rad_bit(longint unsigned v, int b);
    int s;
    s = b - FB;
    if (s < 0 || s > 63) return 0;
    return (v >> s) & 64'd1;
  endfunction

  // rounded sqrt(v * 2^FB), digit by digit
  function automatic longint unsigned root_fx(longint unsigned v);
    longint unsigned root, rem, trial;
    root = 0;
    rem = 0;
    for (int p = 43; p >= 0; p--) begin
      rem = (rem << 2) | (rad_bit(v, 2*p+1) << 1) | rad_bit(v, 2*p);
      trial = (root << 2) | 64'd1;
      root = root << 1;
      if (rem >= trial) begin
        rem = rem - trial;
        root = root | 64'd1;
      end
    end
    if (rem > root) root++;
    return root;
  endfunction

  function automatic int dim_now();
    if (size_reg < 2) return 2;
    if (size_reg > N_MAX) return N_MAX;
    return int'(size_reg);
  endfunction

  // append one expected result item
  function automatic void expect_elem(qr_elem_t e);
    expected_elems = {expected_elems, e};
  endfunction

  // run the decomposition of the loaded matrix and queue q then r
  function automatic void predict_qr(int n);
    logic signed [ELEM_W-1:0] acol [N_MAX][N_MAX];
    longint                   acc [N_MAX];
    logic signed [ELEM_W-1:0] c;
    longint unsigned          m;
    bit                       zseen;
    qr_elem_t                 e;
    zseen = 0;
    for (int k = 0; k < N_MAX; k++)
      for (int r = 0; r < N_MAX; r++) acol[k][r] = (k < n && r < n) ? a_mem[r*n+k] : 0;
    for (int i = 0; i < n; i++) begin
      for (int r = 0; r < n; r++) acc[r] = acol[i][r];
      for (int j = 0; j < i; j++) begin
        if (nsq[j] != 0) begin
          c = div_fx(dot_fx(acol[i], basis[j], n), nsq[j]);
          for (int r = 0; r < n; r++) acc[r] -= rnd_q(longint'(c) * longint'(basis[j][r]));
        end
      end
      for (int r = 0; r < n; r++) basis[i][r] = clamp32(acc[r]);
      nsq[i] = dot_fx(basis[i], basis[i], n);
    end
    for (int i = 0; i < n; i++) begin
      if (nsq[i] <= 0) begin
        zseen = 1;
        for (int r = 0; r < n; r++) basis[i][r] = 0;
      end else begin
        m = root_fx(nsq[i]);
        for (int r = 0; r < n; r++) basis[i][r] = div_fx(longint'(basis[i][r]), m);
      end
    end
    for (int r = 0; r < n; r++)
      for (int k = 0; k < n; k++) begin
        e.which_matrix = MATRIX_Q;
        e.row_index = IDX_W'(r);
        e.col_index = IDX_W'(k);
        e.result_value = basis[k][r];
        e.zero_norm_seen = zseen;
        e.last_result = 1'b0;
        expect_elem(e);
      end
    for (int i = 0; i < n; i++)
      for (int k = 0; k < n; k++) begin
        e.which_matrix = MATRIX_R;
        e.row_index = IDX_W'(i);
        e.col_index = IDX_W'(k);
        e.result_value = clamp32(dot_fx(basis[i], acol[k], n));
        e.zero_norm_seen = zseen;
        e.last_result = (i == n-1 && k == n-1);
        expect_elem(e);
      end
  endfunction

  function automatic void load_elem(logic signed [ELEM_W-1:0] v);
    int n;
    n = dim_now();
    if (load_cnt >= n*n) load_cnt = 0;
    a_mem[load_cnt] = v;
    load_cnt++;
    if (load_cnt == n*n) begin
      load_cnt = 0;
      predict_qr(n);
    end
  endfunction

  // result side: random stall per item, long hold-off on request
  int rx_hold;
  always @(posedge clk) begin
    logic nxt_ready;
    qr_elem_t e;
    nxt_ready = out_ch.ready;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_elems.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result item r=%0d c=%0d v=%0d",
                                       out_ch.row_index, out_ch.col_index, out_ch.result_value);
      end else begin
        e = expected_elems.pop_front();
        if (out_ch.which_matrix !== e.which_matrix || out_ch.row_index !== e.row_index ||
            out_ch.col_index !== e.col_index || out_ch.result_value !== e.result_value ||
            out_ch.zero_norm_seen !== e.zero_norm_seen || out_ch.last_result !== e.last_result)
        begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch exp m=%0d r=%0d c=%0d v=%0d z=%0d l=%0d",
                     e.which_matrix, e.row_index, e.col_index, e.result_value,
                     e.zero_norm_seen, e.last_result);
            $display("         got m=%0d r=%0d c=%0d v=%0d z=%0d l=%0d",
                     out_ch.which_matrix, out_ch.row_index, out_ch.col_index,
                     out_ch.result_value, out_ch.zero_norm_seen, out_ch.last_result);
          end
        end
      end
      rx_hold = fast_mode ? 0 : $urandom_range(0, 9);
    end
    if (long_hold_req) begin
      long_hold_req = 0;
      rx_hold = LONG_HOLD;
    end
    if (!rst_n) begin
      nxt_ready = 1'b0;
    end else if (rx_hold > 0) begin
      rx_hold--;
      nxt_ready = 1'b0;
    end else begin
      nxt_ready = 1'b1;
    end
    out_ch.ready <= nxt_ready;
  end

  // watchdog on cycles without any accepted item
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready) || !rst_n) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= WDOG_MAX) begin
        $display("FAIL gram_schmidt_qr_core");
        $finish;
      end
    end
  end

  // send one element, valid stays high into the next item when no gap is drawn
  task automatic send_elem(logic signed [ELEM_W-1:0] v);
    int gap;
    gap = fast_mode ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.element_value <= v;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    load_elem(v);
    items_sent++;
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (expected_elems.size() != 0) @(posedge clk);
    repeat (DRAIN_GAP) @(posedge clk);
  endtask

  task automatic write_size(logic [SIZE_W-1:0] s);
    cfg_ch.valid <= 1'b1;
    cfg_ch.size_in_use <= s;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
    size_reg = s;
    load_cnt = 0;
  endtask

  function automatic logic signed [ELEM_W-1:0] rand_elem();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 65) return $signed($urandom_range(0, 2*(1 << 20))) - (1 << 20);
    if (sel < 85) return $urandom;
    if (sel < 90) return ELEM_MAX;
    if (sel < 95) return ELEM_MIN;
    return 0;
  endfunction

  task automatic send_matrix(int n);
    for (int i = 0; i < n*n; i++) send_elem(rand_elem());
  endtask

  // directed: extremes, zero norm, saturated coefficient, identity
  task automatic test_directed();
    write_size(3'd2);
    send_elem(ELEM_MAX); send_elem(ELEM_MIN); send_elem(ELEM_MIN); send_elem(ELEM_MAX);
    send_elem(0); send_elem(0); send_elem(0); send_elem(0);
    send_elem(32'sd256); send_elem(ELEM_MAX); send_elem(0); send_elem(ELEM_MIN);
    send_elem(32'sd65536); send_elem(0); send_elem(0); send_elem(32'sd65536);
    send_elem(32'sd1); send_elem(-32'sd1); send_elem(32'sd65536); send_elem(-32'sd65536);
    wait_drained();
  endtask

  // clamped sizes, every register value
  task automatic test_sizes();
    logic [SIZE_W-1:0] sizes[8] = '{3'd3, 3'd0, 3'd7, 3'd1, 3'd6, 3'd2, 3'd4, 3'd5};
    foreach (sizes[i]) begin
      write_size(sizes[i]);
      send_matrix(dim_now());
      wait_drained();
    end
  endtask

  // size written while a matrix is half loaded
  task automatic test_abandoned_load();
    write_size(3'd3);
    for (int i = 0; i < 4; i++) send_elem(rand_elem());
    in_ch.valid <= 1'b0;
    repeat (20) @(posedge clk);
    write_size(3'd3);
    send_matrix(3);
    wait_drained();
  endtask

  // receiver held off while the sender keeps offering matrices
  task automatic test_backpressure();
    write_size(3'd2);
    long_hold_req = 1;
    for (int i = 0; i < 3; i++) send_matrix(2);
    wait_drained();
  endtask

  // no idling on either side
  task automatic test_full_rate();
    write_size(3'd4);
    fast_mode = 1;
    send_matrix(4);
    send_matrix(4);
    wait_drained();
    fast_mode = 0;
  endtask

  // random sizes until the item budget is spent
  task automatic test_random();
    logic [SIZE_W-1:0] s;
    while (items_sent < 260) begin
      s = ($urandom_range(0, 4) == 0) ? 3'(5) : 3'($urandom_range(0, 7));
      write_size(s);
      repeat ($urandom_range(1, 3)) send_matrix(dim_now());
      wait_drained();
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.element_value = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.size_in_use = '0;
    out_ch.ready = 1'b0;
    mismatches = 0;
    items_sent = 0;
    fast_mode = 0;
    long_hold_req = 0;
    idle_cycles = 0;
    rx_hold = 0;
    load_cnt = 0;
    size_reg = SIZE_RESET;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_sizes();
    test_abandoned_load();
    test_backpressure();
    test_full_rate();
    test_random();
    wait_drained();
    if (mismatches == 0) begin
      $display("PASS gram_schmidt_qr_core");
    end else begin
      $display("FAIL gram_schmidt_qr_core");
    end
    $finish;
  end

endmodule

`default_nettype wire
